@@ design/hbpm_pkg.sv @@
`timescale 1ns / 1ps

package hbpm_pkg;

   localparam int ZONE_W    = 32;
   localparam int BIT_CNT_W = $clog2(ZONE_W);

   typedef enum logic [1:0] {
      ACT_ALLOCATE = 2'd0,
      ACT_FREE     = 2'd1,
      ACT_LOOKUP   = 2'd2,
      ACT_SET_TYPE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_PRESENT = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   localparam logic KIND_OUTPUT = 1'b0;
   localparam logic KIND_RESCUE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_BKT_RD,
      ST_BKT,
      ST_WALK,
      ST_DECIDE,
      ST_ALLOC_WR,
      ST_FREE_UNLINK,
      ST_FREE_PUSH,
      ST_RETYPE,
      ST_FINISH
   } state_type;

endpackage

@@ design/hashed_buffer_pool_manager_top.sv @@
`timescale 1ns / 1ps

// Pool manager for POOL_DEPTH buffer slots keyed by a 32-bit zone number, with a LIFO free
// list and HASH_BUCKETS head-insert chains. One request is handled at a time. After reset a
// clearing pass initializes the bucket heads and the free chain while req_ready stays low.
// A request is then hashed to a bucket (bit-serially when HASH_BUCKETS is not a power of
// two), the bucket head is read and the chain is walked until the zone matches or the chain
// ends; a successful allocate or set type then writes the slot, and a successful free
// unlinks the slot and pushes it onto the free list. The walk is paced by the slot memory,
// whose single registered read port visits one chain entry per cycle. A finished result
// sits in an output register until it is taken, and the next request is taken meanwhile.

module hashed_buffer_pool_manager_top #(
   parameter int POOL_DEPTH   = 512,
   parameter int HASH_BUCKETS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic [hbpm_pkg::ZONE_W-1:0]         req_zone,
   input  logic                                req_buffer_type,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic [$clog2(POOL_DEPTH)-1:0]       rsp_slot,
   output logic                                rsp_slot_type,
   output logic [$clog2(POOL_DEPTH+1)-1:0]     rsp_free_count,
   output logic [$clog2(POOL_DEPTH+1)-1:0]     rsp_output_count,
   output logic [$clog2(POOL_DEPTH+1)-1:0]     rsp_rescue_count
);

   localparam int SLOT_W  = $clog2(POOL_DEPTH);
   localparam int BKT_W   = $clog2(HASH_BUCKETS);
   localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
   localparam int CLR_LEN = (HASH_BUCKETS > POOL_DEPTH) ? HASH_BUCKETS : POOL_DEPTH;
   localparam int CLR_W   = $clog2(CLR_LEN);
   localparam bit HASH_POW2 = ((HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0);

   localparam logic [BKT_W:0]   HASH_VAL  = (BKT_W + 1)'(HASH_BUCKETS);
   localparam logic [CLR_W:0]   BKT_LIM   = (CLR_W + 1)'(HASH_BUCKETS);
   localparam logic [CLR_W:0]   POOL_LIM  = (CLR_W + 1)'(POOL_DEPTH);
   localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_LEN - 1);
   localparam logic [CNT_W-1:0] POOL_CNT  = CNT_W'(POOL_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   // A chain link or a bucket head: a slot index and whether it points anywhere.
   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] idx;
   } link_type;

   // Memories.
   link_type                         bucket_mem_ff [HASH_BUCKETS];
   logic [hbpm_pkg::ZONE_W-1:0]      zone_mem_ff   [POOL_DEPTH];
   link_type                         link_mem_ff   [POOL_DEPTH];
   logic                             kind_mem_ff   [POOL_DEPTH];

   link_type                         bucket_rd_ff;
   logic [hbpm_pkg::ZONE_W-1:0]      zone_rd_ff;
   link_type                         link_rd_ff;
   logic                             kind_rd_ff;

   // Sequencer and datapath registers.
   hbpm_pkg::state_type              state_ff, state_in;
   logic [CLR_W-1:0]                 clr_cnt_ff, clr_cnt_in;
   hbpm_pkg::action_type             act_ff, act_in;
   logic [hbpm_pkg::ZONE_W-1:0]      zone_ff, zone_in;
   logic                             btype_ff, btype_in;
   logic [hbpm_pkg::BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [BKT_W-1:0]                 rem_ff, rem_in;
   link_type                         bkt_ff, bkt_in;
   logic [SLOT_W-1:0]                cur_ff, cur_in;
   logic [SLOT_W-1:0]                prev_ff, prev_in;
   logic                             has_prev_ff, has_prev_in;
   logic                             hit_ff, hit_in;
   logic [SLOT_W-1:0]                hit_slot_ff, hit_slot_in;
   link_type                         hit_link_ff, hit_link_in;
   logic                             hit_kind_ff, hit_kind_in;
   logic [SLOT_W-1:0]                free_head_ff, free_head_in;
   logic                             free_ok_ff, free_ok_in;
   logic [CNT_W-1:0]                 free_total_ff, free_total_in;
   logic [CNT_W-1:0]                 output_total_ff, output_total_in;
   logic [CNT_W-1:0]                 rescue_total_ff, rescue_total_in;
   hbpm_pkg::status_type             res_status_ff, res_status_in;
   logic [SLOT_W-1:0]                res_slot_ff, res_slot_in;
   logic                             res_type_ff, res_type_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   hbpm_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]                rsp_slot_ff, rsp_slot_in;
   logic                             rsp_type_ff, rsp_type_in;
   logic [CNT_W-1:0]                 rsp_free_ff, rsp_free_in;
   logic [CNT_W-1:0]                 rsp_output_ff, rsp_output_in;
   logic [CNT_W-1:0]                 rsp_rescue_ff, rsp_rescue_in;

   // Control decoded from the state.
   logic                             req_accept;
   logic                             rsp_load;
   logic                             clr_last;
   logic                             hash_last;
   logic                             walk_match;
   logic                             pool_empty;
   logic [BKT_W:0]                   rem_shift;
   logic                             bkt_we;
   logic [BKT_W-1:0]                 bkt_waddr;
   link_type                         bkt_wdata;
   logic                             link_we;
   logic [SLOT_W-1:0]                link_waddr;
   link_type                         link_wdata;
   logic                             zone_we;
   logic                             kind_we;
   logic [SLOT_W-1:0]                kind_waddr;
   logic [SLOT_W-1:0]                ent_raddr;

   assign req_accept = req_valid && req_ready;
   assign clr_last   = (clr_cnt_ff == CLR_LAST);
   assign hash_last  = HASH_POW2 || (bit_cnt_ff == '0);
   assign walk_match = (zone_rd_ff == zone_ff);
   assign pool_empty = !free_ok_ff || (free_total_ff == '0);
   assign rem_shift  = {rem_ff, zone_ff[bit_cnt_ff]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbpm_pkg::ST_CLEAR: begin
            if (clr_last) state_in = hbpm_pkg::ST_IDLE;
         end
         hbpm_pkg::ST_IDLE: begin
            if (req_valid) state_in = hbpm_pkg::ST_HASH;
         end
         hbpm_pkg::ST_HASH: begin
            if (hash_last) state_in = hbpm_pkg::ST_BKT_RD;
         end
         hbpm_pkg::ST_BKT_RD: state_in = hbpm_pkg::ST_BKT;
         hbpm_pkg::ST_BKT: begin
            state_in = bucket_rd_ff.ok ? hbpm_pkg::ST_WALK : hbpm_pkg::ST_DECIDE;
         end
         hbpm_pkg::ST_WALK: begin
            if (walk_match || !link_rd_ff.ok) state_in = hbpm_pkg::ST_DECIDE;
         end
         hbpm_pkg::ST_DECIDE: begin
            case (act_ff)
               hbpm_pkg::ACT_ALLOCATE: begin
                  state_in = (pool_empty || hit_ff) ? hbpm_pkg::ST_FINISH
                                                    : hbpm_pkg::ST_ALLOC_WR;
               end
               hbpm_pkg::ACT_FREE: begin
                  state_in = hit_ff ? hbpm_pkg::ST_FREE_UNLINK : hbpm_pkg::ST_FINISH;
               end
               hbpm_pkg::ACT_SET_TYPE: begin
                  state_in = hit_ff ? hbpm_pkg::ST_RETYPE : hbpm_pkg::ST_FINISH;
               end
               default: state_in = hbpm_pkg::ST_FINISH;
            endcase
         end
         hbpm_pkg::ST_ALLOC_WR:    state_in = hbpm_pkg::ST_FINISH;
         hbpm_pkg::ST_FREE_UNLINK: state_in = hbpm_pkg::ST_FREE_PUSH;
         hbpm_pkg::ST_FREE_PUSH:   state_in = hbpm_pkg::ST_FINISH;
         hbpm_pkg::ST_RETYPE:      state_in = hbpm_pkg::ST_FINISH;
         hbpm_pkg::ST_FINISH: begin
            if (rsp_load) state_in = hbpm_pkg::ST_IDLE;
         end
         default: state_in = hbpm_pkg::ST_CLEAR;
      endcase
   end

   // Handshake, memory ports and read address.
   always_comb begin
      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      bkt_we     = 1'b0;
      bkt_waddr  = rem_ff;
      bkt_wdata  = '{ok: 1'b1, idx: free_head_ff};
      link_we    = 1'b0;
      link_waddr = free_head_ff;
      link_wdata = bkt_ff;
      zone_we    = 1'b0;
      kind_we    = 1'b0;
      kind_waddr = free_head_ff;
      ent_raddr  = cur_ff;
      case (state_ff)
         hbpm_pkg::ST_CLEAR: begin
            bkt_we     = ({1'b0, clr_cnt_ff} < BKT_LIM);
            bkt_waddr  = clr_cnt_ff[BKT_W-1:0];
            bkt_wdata  = '{ok: 1'b0, idx: '0};
            // The free chain starts as slot i pointing at slot i + 1.
            link_we    = ({1'b0, clr_cnt_ff} < POOL_LIM);
            link_waddr = clr_cnt_ff[SLOT_W-1:0];
            link_wdata = '{ok:  ({1'b0, clr_cnt_ff} + 1'b1) < POOL_LIM,
                           idx: clr_cnt_ff[SLOT_W-1:0] + 1'b1};
         end
         hbpm_pkg::ST_IDLE:   req_ready = 1'b1;
         hbpm_pkg::ST_BKT:    ent_raddr = bucket_rd_ff.idx;
         hbpm_pkg::ST_WALK:   ent_raddr = link_rd_ff.idx;
         hbpm_pkg::ST_DECIDE: ent_raddr = free_head_ff;
         hbpm_pkg::ST_ALLOC_WR: begin
            bkt_we  = 1'b1;
            link_we = 1'b1;
            zone_we = 1'b1;
            kind_we = 1'b1;
         end
         hbpm_pkg::ST_FREE_UNLINK: begin
            // Splice the slot out of its chain, at the predecessor or at the bucket head.
            bkt_we     = !has_prev_ff;
            bkt_wdata  = hit_link_ff;
            link_we    = has_prev_ff;
            link_waddr = prev_ff;
            link_wdata = hit_link_ff;
         end
         hbpm_pkg::ST_FREE_PUSH: begin
            link_we    = 1'b1;
            link_waddr = hit_slot_ff;
            link_wdata = '{ok: free_ok_ff, idx: free_head_ff};
         end
         hbpm_pkg::ST_RETYPE: begin
            kind_we    = 1'b1;
            kind_waddr = hit_slot_ff;
         end
         hbpm_pkg::ST_FINISH: rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_cnt_in      = clr_cnt_ff;
      act_in          = act_ff;
      zone_in         = zone_ff;
      btype_in        = btype_ff;
      bit_cnt_in      = bit_cnt_ff;
      rem_in          = rem_ff;
      bkt_in          = bkt_ff;
      cur_in          = cur_ff;
      prev_in         = prev_ff;
      has_prev_in     = has_prev_ff;
      hit_in          = hit_ff;
      hit_slot_in     = hit_slot_ff;
      hit_link_in     = hit_link_ff;
      hit_kind_in     = hit_kind_ff;
      free_head_in    = free_head_ff;
      free_ok_in      = free_ok_ff;
      free_total_in   = free_total_ff;
      output_total_in = output_total_ff;
      rescue_total_in = rescue_total_ff;
      res_status_in   = res_status_ff;
      res_slot_in     = res_slot_ff;
      res_type_in     = res_type_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_type_in     = rsp_type_ff;
      rsp_free_in     = rsp_free_ff;
      rsp_output_in   = rsp_output_ff;
      rsp_rescue_in   = rsp_rescue_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         hbpm_pkg::ST_CLEAR: clr_cnt_in = clr_cnt_ff + 1'b1;
         hbpm_pkg::ST_IDLE: begin
            if (req_accept) begin
               act_in      = hbpm_pkg::action_type'(req_action);
               zone_in     = req_zone;
               btype_in    = req_buffer_type;
               bit_cnt_in  = hbpm_pkg::BIT_CNT_W'(hbpm_pkg::ZONE_W - 1);
               rem_in      = '0;
               has_prev_in = 1'b0;
               hit_in      = 1'b0;
            end
         end
         hbpm_pkg::ST_HASH: begin
            // Bucket index is the zone modulo the bucket count, one zone bit per cycle
            // when the count is not a power of two.
            if (HASH_POW2) begin
               rem_in = zone_ff[BKT_W-1:0];
            end else begin
               rem_in = (rem_shift >= HASH_VAL) ? BKT_W'(rem_shift - HASH_VAL)
                                                : BKT_W'(rem_shift);
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         hbpm_pkg::ST_BKT: begin
            bkt_in = bucket_rd_ff;
            cur_in = bucket_rd_ff.idx;
         end
         hbpm_pkg::ST_WALK: begin
            if (walk_match) begin
               hit_in      = 1'b1;
               hit_slot_in = cur_ff;
               hit_link_in = link_rd_ff;
               hit_kind_in = kind_rd_ff;
            end else begin
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               cur_in      = link_rd_ff.idx;
            end
         end
         hbpm_pkg::ST_DECIDE: begin
            res_slot_in   = hit_ff ? hit_slot_ff : '0;
            res_type_in   = hit_ff ? hit_kind_ff : 1'b0;
            res_status_in = hbpm_pkg::STATUS_OK;
            if (act_ff == hbpm_pkg::ACT_ALLOCATE) begin
               if (pool_empty) res_status_in = hbpm_pkg::STATUS_EMPTY;
               else if (hit_ff) res_status_in = hbpm_pkg::STATUS_PRESENT;
            end else if (!hit_ff) begin
               res_status_in = hbpm_pkg::STATUS_MISSING;
            end
         end
         hbpm_pkg::ST_ALLOC_WR: begin
            // The link read here is the successor of the free list head.
            free_head_in  = link_rd_ff.idx;
            free_ok_in    = link_rd_ff.ok;
            free_total_in = free_total_ff - CNT_ONE;
            if (btype_ff == hbpm_pkg::KIND_RESCUE) rescue_total_in = rescue_total_ff + CNT_ONE;
            else output_total_in = output_total_ff + CNT_ONE;
            res_slot_in = free_head_ff;
            res_type_in = btype_ff;
         end
         hbpm_pkg::ST_FREE_PUSH: begin
            free_head_in  = hit_slot_ff;
            free_ok_in    = 1'b1;
            free_total_in = free_total_ff + CNT_ONE;
            if (hit_kind_ff == hbpm_pkg::KIND_RESCUE) rescue_total_in = rescue_total_ff - CNT_ONE;
            else output_total_in = output_total_ff - CNT_ONE;
         end
         hbpm_pkg::ST_RETYPE: begin
            if (hit_kind_ff != btype_ff) begin
               if (btype_ff == hbpm_pkg::KIND_RESCUE) begin
                  rescue_total_in = rescue_total_ff + CNT_ONE;
                  output_total_in = output_total_ff - CNT_ONE;
               end else begin
                  output_total_in = output_total_ff + CNT_ONE;
                  rescue_total_in = rescue_total_ff - CNT_ONE;
               end
            end
            res_type_in = btype_ff;
         end
         hbpm_pkg::ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = hit_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_type_in   = res_type_ff;
               rsp_free_in   = free_total_ff;
               rsp_output_in = output_total_ff;
               rsp_rescue_in = rescue_total_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= hbpm_pkg::ST_CLEAR;
         clr_cnt_ff      <= '0;
         free_head_ff    <= '0;
         free_ok_ff      <= 1'b1;
         free_total_ff   <= POOL_CNT;
         output_total_ff <= '0;
         rescue_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         free_head_ff    <= free_head_in;
         free_ok_ff      <= free_ok_in;
         free_total_ff   <= free_total_in;
         output_total_ff <= output_total_in;
         rescue_total_ff <= rescue_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      zone_ff       <= zone_in;
      btype_ff      <= btype_in;
      bit_cnt_ff    <= bit_cnt_in;
      rem_ff        <= rem_in;
      bkt_ff        <= bkt_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      has_prev_ff   <= has_prev_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_link_ff   <= hit_link_in;
      hit_kind_ff   <= hit_kind_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_type_ff   <= res_type_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_output_ff <= rsp_output_in;
      rsp_rescue_ff <= rsp_rescue_in;
   end

   // Bucket head memory.
   always_ff @(posedge clock) begin
      if (bkt_we) bucket_mem_ff[bkt_waddr] <= bkt_wdata;
      bucket_rd_ff <= bucket_mem_ff[rem_ff];
   end

   // Slot memories share one read address.
   always_ff @(posedge clock) begin
      if (zone_we) zone_mem_ff[free_head_ff] <= zone_ff;
      zone_rd_ff <= zone_mem_ff[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem_ff[link_waddr] <= link_wdata;
      link_rd_ff <= link_mem_ff[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (kind_we) kind_mem_ff[kind_waddr] <= btype_ff;
      kind_rd_ff <= kind_mem_ff[ent_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_slot_type    = rsp_type_ff;
   assign rsp_free_count   = rsp_free_ff;
   assign rsp_output_count = rsp_output_ff;
   assign rsp_rescue_count = rsp_rescue_ff;

endmodule

@@ design/hbpm_checker.sv @@
`timescale 1ns / 1ps

module hbpm_checker #(
   parameter int POOL_DEPTH = 512
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [1:0]                          req_action,
   input logic [hbpm_pkg::ZONE_W-1:0]         req_zone,
   input logic                                req_buffer_type,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          rsp_status,
   input logic                                rsp_found,
   input logic [$clog2(POOL_DEPTH)-1:0]       rsp_slot,
   input logic                                rsp_slot_type,
   input logic [$clog2(POOL_DEPTH+1)-1:0]     rsp_free_count,
   input logic [$clog2(POOL_DEPTH+1)-1:0]     rsp_output_count,
   input logic [$clog2(POOL_DEPTH+1)-1:0]     rsp_rescue_count
);

   localparam int SUM_W = $clog2(POOL_DEPTH + 1) + 2;

   logic [SUM_W-1:0] count_sum;

   assign count_sum = SUM_W'(rsp_free_count) + SUM_W'(rsp_output_count)
                    + SUM_W'(rsp_rescue_count);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_found) && $stable(rsp_slot_type) && $stable(rsp_free_count))
      else $error("result changed while stalled");

   // Once a request is taken, req_ready drops while it is in progress.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in progress");

   // Every slot is free, of output type or of rescue type.
   a_count_conserved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_sum == SUM_W'(POOL_DEPTH))
      else $error("slot counts do not add up to the pool depth");

   a_missing_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == hbpm_pkg::STATUS_MISSING
         |-> !rsp_found && rsp_slot == '0 && !rsp_slot_type)
      else $error("not-found result carries a slot");

   a_empty_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == hbpm_pkg::STATUS_EMPTY |-> rsp_free_count == '0)
      else $error("pool-empty status with free slots left");

endmodule

bind hashed_buffer_pool_manager_top hbpm_checker #(.POOL_DEPTH(POOL_DEPTH)) u_hbpm_checker (.*);
